// ===== rtl/ifp_pkg.sv =====
`default_nettype none
package ifp_pkg;

    localparam int unsigned SLOT_COUNT = 11;
    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
    localparam int unsigned PAY_W      = 64;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned POS_W      = 4;

    localparam logic [7:0] START_BYTE = 8'h55;
    localparam logic [7:0] FIRST_TYPE = 8'h50;
    localparam logic [7:0] LAST_TYPE  = 8'h5a;
    localparam logic [POS_W-1:0] SUM_POS = 4'd10;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot_index;
        logic [PAY_W-1:0]   payload;
        logic [SEQ_W-1:0]   sequence_res;
        logic               last;
    } t_res_word;

    typedef struct packed {
        logic               err;
        logic               pub;
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_idx;
        logic [PAY_W-1:0]   wr_data;
    } t_parse_ev;

    typedef enum logic [2:0] {
        STEP_FETCH    = 3'd0,
        STEP_DISPATCH = 3'd1,
        STEP_READ     = 3'd2,
        STEP_EMIT     = 3'd3,
        STEP_RETURN   = 3'd4,
        STEP_ERROR    = 3'd5
    } t_step;

    typedef enum logic [1:0] {
        OSEL_NONE = 2'd0,
        OSEL_SLOT = 2'd1,
        OSEL_ERR  = 2'd2
    } t_osel;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_OUT  = 2'd2
    } t_hold;

    typedef enum logic [2:0] {
        J_NEVER  = 3'd0,
        J_ALWAYS = 3'd1,
        J_QUIET  = 3'd2,
        J_ERR    = 3'd3,
        J_MORE   = 3'd4
    } t_jcond;

    typedef struct packed {
        logic   in_rdy;
        logic   rd_en;
        logic   cnt_clr;
        logic   cnt_inc;
        t_osel  osel;
        t_hold  hold;
        t_jcond jc;
        t_step  target;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{in_rdy: 1'b0, rd_en: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0,
              osel: OSEL_NONE, hold: HOLD_NONE, jc: J_ALWAYS, target: STEP_FETCH};
        unique case (s)
            STEP_FETCH: begin
                w.in_rdy = 1'b1;
                w.hold   = HOLD_IN;
                w.jc     = J_QUIET;
                w.target = STEP_FETCH;
            end
            STEP_DISPATCH: begin
                w.cnt_clr = 1'b1;
                w.jc      = J_ERR;
                w.target  = STEP_ERROR;
            end
            STEP_READ: begin
                w.rd_en = 1'b1;
                w.jc    = J_NEVER;
            end
            STEP_EMIT: begin
                w.hold    = HOLD_OUT;
                w.osel    = OSEL_SLOT;
                w.cnt_inc = 1'b1;
                w.jc      = J_MORE;
                w.target  = STEP_READ;
            end
            STEP_RETURN: begin
                w.jc     = J_ALWAYS;
                w.target = STEP_FETCH;
            end
            STEP_ERROR: begin
                w.hold   = HOLD_OUT;
                w.osel   = OSEL_ERR;
                w.jc     = J_ALWAYS;
                w.target = STEP_FETCH;
            end
            default: begin
                w.jc     = J_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ifp_stream_if.sv =====
`default_nettype none
interface ifp_stream_if #(
    parameter type T = ifp_pkg::t_in_word
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/imu_serial_frame_parser_top.sv =====
`default_nettype none
// byte-stream frame parser with additive checksum
// i_in carries one received byte per word; o_res carries result words
// (status, slot_index, payload, sequence_res, last)
// a byte is taken only while the sequencer sits in its fetch step;
// a byte that causes no result frees the block for the next byte at once
// a checksum error passes through the dispatch and error steps and emits one word
// with status and last set; a publish run passes through dispatch, a read and an
// emit step per slot, and return, and emits 11 words, slot 0 first, the last one
// marked; the pace is set by the slot ram read port, one registered read per slot
// the first word of a run is loaded into the output register in its emit step
// results pass through a single output register, so a stalled receiver holds the
// sequencer in its emit or error step once a new word is due, and no byte is taken
// reset clears sync, the slot valid bits (all slots then read as zero),
// the highest type seen and the sequence count; no clearing pass is needed
module imu_serial_frame_parser_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ifp_stream_if.sink   i_in,
    ifp_stream_if.source o_res
);
    import ifp_pkg::*;

    t_step              r_step, n_step;
    t_uword             w_uw;
    logic               w_accept;
    logic               w_out_busy;
    logic               w_held;
    logic               w_jump;

    t_parse_ev          w_ev;
    logic [SEQ_W-1:0]   w_seq;

    logic               r_err;
    logic [SLOT_W-1:0]  r_cnt;
    logic [SLOT_COUNT-1:0] r_vld;
    logic               r_rd_vld;
    logic [PAY_W-1:0]   w_rdata;

    logic               r_ovalid;
    t_res_word          r_odata;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_busy = r_ovalid && !o_res.ready;

    ifp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.data.rx_byte),
        .o_ev     (w_ev),
        .o_seq    (w_seq)
    );

    ifp_ram #(
        .WIDTH (PAY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ev.wr_en),
        .i_waddr (w_ev.wr_idx),
        .i_wdata (w_ev.wr_data),
        .i_re    (w_uw.rd_en),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    // control word fetch
    always_comb begin
        w_uw = ucode(r_step);
    end

    assign i_in.ready = w_uw.in_rdy;

    always_comb begin
        priority case (w_uw.hold)
            HOLD_IN:  w_held = !w_accept;
            HOLD_OUT: w_held = w_out_busy;
            default:  w_held = 1'b0;
        endcase
        unique case (w_uw.jc)
            J_NEVER:  w_jump = 1'b0;
            J_ALWAYS: w_jump = 1'b1;
            J_QUIET:  w_jump = !w_ev.err && !w_ev.pub;
            J_ERR:    w_jump = r_err;
            J_MORE:   w_jump = (r_cnt != SLOT_W'(SLOT_COUNT - 1));
            default:  w_jump = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (w_held) begin
            n_step = r_step;
        end else if (w_jump) begin
            n_step = w_uw.target;
        end else begin
            n_step = t_step'(r_step + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_FETCH;
            r_err    <= 1'b0;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_accept) begin
                r_err <= w_ev.err;
            end
            if (w_uw.cnt_clr) begin
                r_cnt <= '0;
            end else if (w_uw.cnt_inc && !w_held && w_jump) begin
                r_cnt <= r_cnt + SLOT_W'(1);
            end
            if (w_ev.wr_en) begin
                r_vld[w_ev.wr_idx] <= 1'b1;
            end
            if (w_uw.osel != OSEL_NONE && !w_held) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.rd_en) begin
            r_rd_vld <= r_vld[r_cnt];
        end
        if (!w_held) begin
            priority case (w_uw.osel)
                OSEL_SLOT: begin
                    r_odata.status       <= 1'b0;
                    r_odata.slot_index   <= r_cnt;
                    r_odata.payload      <= r_rd_vld ? w_rdata : '0;
                    r_odata.sequence_res <= w_seq;
                    r_odata.last         <= (r_cnt == SLOT_W'(SLOT_COUNT - 1));
                end
                OSEL_ERR: begin
                    r_odata.status       <= 1'b1;
                    r_odata.slot_index   <= '0;
                    r_odata.payload      <= '0;
                    r_odata.sequence_res <= '0;
                    r_odata.last         <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.status) |->
            (o_res.data.last && o_res.data.slot_index == '0
             && o_res.data.payload == '0 && o_res.data.sequence_res == '0))
        else $error("error word carries nonzero fields");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.status) |->
            (o_res.data.last == (o_res.data.slot_index == SLOT_W'(SLOT_COUNT - 1))))
        else $error("last flag does not match final slot");

    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_ev.err || w_ev.pub)) |=> (r_step == STEP_DISPATCH))
        else $error("frame end did not reach dispatch");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < SLOT_W'(SLOT_COUNT))
        else $error("slot counter out of range");

    a_seq_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_FETCH && $past(r_step) != STEP_FETCH) |-> $stable(w_seq))
        else $error("sequence count moved during a run");

endmodule
`default_nettype wire

// ===== rtl/ifp_ram.sv =====
`default_nettype none
module ifp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ifp_parser.sv =====
`default_nettype none
module ifp_parser (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [7:0]               i_byte,
    output ifp_pkg::t_parse_ev            o_ev,
    output logic [ifp_pkg::SEQ_W-1:0]     o_seq
);
    import ifp_pkg::*;

    logic               r_synced, n_synced;
    logic               r_saw, n_saw;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_type, n_type;
    logic [PAY_W-1:0]   r_payload, n_payload;
    logic [7:0]         r_hi, n_hi;
    logic [SEQ_W-1:0]   r_seq, n_seq;

    logic               w_at_sum;
    logic               w_good;
    logic [2:0]         w_lane;

    assign w_at_sum = i_accept && r_synced && (r_pos >= SUM_POS);
    assign w_good   = w_at_sum && (i_byte == r_sum);
    assign w_lane   = 3'(r_pos - POS_W'(2));

    always_comb begin
        o_ev.err     = w_at_sum && (i_byte != r_sum);
        o_ev.pub     = w_good && (r_type >= r_hi);
        o_ev.wr_en   = w_good && (r_type >= FIRST_TYPE) && (r_type <= LAST_TYPE);
        o_ev.wr_idx  = SLOT_W'(r_type - FIRST_TYPE);
        o_ev.wr_data = r_payload;
    end

    assign o_seq = r_seq;

    always_comb begin
        n_synced  = r_synced;
        n_saw     = r_saw;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_type    = r_type;
        n_payload = r_payload;
        n_hi      = r_hi;
        n_seq     = r_seq;
        if (i_accept) begin
            if (!r_synced) begin
                if (r_saw && (i_byte == FIRST_TYPE)) begin
                    n_synced  = 1'b1;
                    n_saw     = 1'b0;
                    n_pos     = POS_W'(2);
                    n_sum     = START_BYTE + FIRST_TYPE;
                    n_type    = FIRST_TYPE;
                    n_payload = '0;
                end else begin
                    n_saw = (i_byte == START_BYTE);
                end
            end else if (r_pos == POS_W'(0)) begin
                n_sum     = i_byte;
                n_payload = '0;
                n_pos     = POS_W'(1);
            end else if (r_pos == POS_W'(1)) begin
                n_sum  = r_sum + i_byte;
                n_type = i_byte;
                n_pos  = POS_W'(2);
            end else if (r_pos < SUM_POS) begin
                n_sum = r_sum + i_byte;
                for (int i = 0; i < 8; i++) begin
                    if (w_lane == 3'(i)) begin
                        n_payload[i*8 +: 8] = i_byte;
                    end
                end
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_pos = '0;
                if (i_byte != r_sum) begin
                    n_synced = 1'b0;
                    n_saw    = 1'b0;
                end else begin
                    if (r_type > r_hi) begin
                        n_hi = r_type;
                    end
                    if (r_type >= r_hi) begin
                        n_seq = r_seq + SEQ_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_saw    <= 1'b0;
            r_pos    <= '0;
            r_hi     <= '0;
            r_seq    <= '0;
        end else begin
            r_synced <= n_synced;
            r_saw    <= n_saw;
            r_pos    <= n_pos;
            r_hi     <= n_hi;
            r_seq    <= n_seq;
        end
        r_sum     <= n_sum;
        r_type    <= n_type;
        r_payload <= n_payload;
    end
endmodule
`default_nettype wire

// ===== tb/sv/imu_serial_frame_parser_top_test.sv =====
`default_nettype none
module imu_serial_frame_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ifp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_BYTES  = 280;
    localparam int HOLD_OFF_LONG = 300;

    localparam logic STATUS_SLOT = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;

    localparam logic [7:0] KIND_BELOW = 8'h00;
    localparam logic [7:0] KIND_ABOVE = 8'hff;
    localparam logic [7:0] HDR_OTHER  = 8'haa;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ifp_stream_if #(.T(t_in_word))  byte_if ();
    ifp_stream_if #(.T(t_res_word)) res_if ();

    imu_serial_frame_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // frame tracker state
    logic              in_sync;
    logic              start_seen;
    logic [POS_W-1:0]  frame_pos;
    logic [7:0]        frame_sum;
    logic [7:0]        frame_kind;
    logic [PAY_W-1:0]  frame_data;
    logic [PAY_W-1:0]  slot_store [SLOT_COUNT];
    logic [7:0]        top_kind;
    logic [SEQ_W-1:0]  publish_count;

    t_res_word due_words [$];

    int  errors = 0;
    int  cycles = 0;
    int  bytes_sent = 0;
    int  words_checked = 0;
    int  n_publish = 0;
    int  n_csum_err = 0;
    int  n_quiet = 0;
    int  n_outside = 0;
    int  hold_off_cycles = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;

    task automatic clear_tracker();
        in_sync       = 1'b0;
        start_seen    = 1'b0;
        frame_pos     = '0;
        frame_sum     = '0;
        frame_kind    = '0;
        frame_data    = '0;
        top_kind      = '0;
        publish_count = '0;
        for (int i = 0; i < SLOT_COUNT; i++) slot_store[i] = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        t_res_word w;
        if (!in_sync) begin
            if (start_seen && b == FIRST_TYPE) begin
                in_sync    = 1'b1;
                start_seen = 1'b0;
                frame_pos  = 4'd2;
                frame_sum  = START_BYTE + FIRST_TYPE;
                frame_kind = FIRST_TYPE;
                frame_data = '0;
            end else begin
                start_seen = (b == START_BYTE);
            end
            return;
        end
        if (frame_pos == 4'd0) begin
            frame_sum  = b;
            frame_data = '0;
            frame_pos  = 4'd1;
            return;
        end
        if (frame_pos == 4'd1) begin
            frame_sum  = frame_sum + b;
            frame_kind = b;
            frame_pos  = 4'd2;
            return;
        end
        if (frame_pos < SUM_POS) begin
            frame_sum = frame_sum + b;
            frame_data[8 * (frame_pos - 2) +: 8] = b;
            frame_pos = frame_pos + 4'd1;
            return;
        end
        // checksum byte
        frame_pos = '0;
        if (b != frame_sum) begin
            in_sync        = 1'b0;
            start_seen     = 1'b0;
            w.status       = STATUS_ERR;
            w.slot_index   = '0;
            w.payload      = '0;
            w.sequence_res = '0;
            w.last         = 1'b1;
            due_words.push_back(w);
            n_csum_err++;
            return;
        end
        if (frame_kind >= FIRST_TYPE && frame_kind <= LAST_TYPE)
            slot_store[frame_kind - FIRST_TYPE] = frame_data;
        else
            n_outside++;
        if (frame_kind > top_kind) top_kind = frame_kind;
        if (frame_kind != top_kind) begin
            n_quiet++;
            return;
        end
        publish_count = publish_count + 1'b1;
        n_publish++;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            w.status       = STATUS_SLOT;
            w.slot_index   = k[SLOT_W-1:0];
            w.payload      = slot_store[k];
            w.sequence_res = publish_count;
            w.last         = (k == SLOT_COUNT - 1);
            due_words.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at result word %0d: got %0h, want %0h",
                 what, words_checked, got, want);
        errors++;
    endtask

    task automatic check_word(input t_res_word got);
        t_res_word want;
        if (due_words.size() == 0) begin
            report_mismatch("unexpected word", got.payload, '0);
            return;
        end
        want = due_words.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
        if (got.payload !== want.payload)
            report_mismatch("payload", got.payload, want.payload);
        if (got.sequence_res !== want.sequence_res)
            report_mismatch("sequence_res", 64'(got.sequence_res),
                            64'(want.sequence_res));
        if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
        words_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) check_word(res_if.data);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d words still due",
                     cycles, due_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_gap(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver side
    initial begin
        int n;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                res_if.ready <= 1'b1;
            end else begin
                n = draw_gap(rx_stalls);
                if (n == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    task automatic pace();
        int n;
        n = draw_gap(tx_gaps);
        if (n > 0) begin
            byte_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        byte_if.valid <= 1'b1;
        byte_if.data  <= t_in_word'{rx_byte: b};
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
        pace();
    endtask

    function automatic logic [PAY_W-1:0] draw_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] kind,
                              input logic [PAY_W-1:0] pay, input bit bad_sum);
        logic [7:0] sum;
        sum = hdr + kind;
        send_byte(hdr);
        send_byte(kind);
        for (int i = 0; i < 8; i++) begin
            sum = sum + pay[8 * i +: 8];
            send_byte(pay[8 * i +: 8]);
        end
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // back on a frame boundary, synced
    task automatic align_frame();
        while (in_sync && frame_pos != 0) send_byte(8'($urandom_range(0, 255)));
        if (!in_sync) send_frame(START_BYTE, FIRST_TYPE, draw_payload(), 1'b0);
    endtask

    task automatic test_sync_search();
        // lone type byte, then a repeated start byte before the pair
        send_byte(FIRST_TYPE);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(FIRST_TYPE);
        for (int i = 0; i < 8; i++) send_byte(8'hff);
        send_byte(START_BYTE + FIRST_TYPE + 8'hf8);
    endtask

    task automatic test_checksum_error();
        send_frame(HDR_OTHER, LAST_TYPE, '0, 1'b1);
        // unsynced again, so a lone type byte must not sync
        send_byte(FIRST_TYPE);
    endtask

    task automatic test_random_frames();
        int start;
        int r;
        int k;
        logic [7:0] kind;
        logic [7:0] hdr;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (!in_sync) begin
                if (r < 15)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_frame(START_BYTE, FIRST_TYPE, draw_payload(),
                               $urandom_range(0, 9) == 0);
            end else if (r < 6) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (r < 9) begin
                wait_drained();
            end else begin
                k = $urandom_range(0, 99);
                if (k < 60)
                    kind = 8'($urandom_range(FIRST_TYPE, LAST_TYPE));
                else if (k < 85)
                    kind = top_kind;
                else
                    kind = 8'($urandom_range(0, FIRST_TYPE - 1));
                hdr = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : START_BYTE;
                send_frame(hdr, kind, draw_payload(), $urandom_range(0, 9) == 0);
            end
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_outside_range();
        align_frame();
        send_frame(START_BYTE, KIND_BELOW, draw_payload(), 1'b0);
        send_frame(START_BYTE, KIND_ABOVE, '1, 1'b0);
        send_frame(HDR_OTHER, FIRST_TYPE + 8'd3, draw_payload(), 1'b0);
        send_frame(START_BYTE, KIND_ABOVE, draw_payload(), 1'b0);
    endtask

    task automatic test_output_backpressure();
        align_frame();
        tx_gaps = 1'b0;
        hold_off_cycles = HOLD_OFF_LONG;
        repeat (4) send_frame(START_BYTE, top_kind, draw_payload(), 1'b0);
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.data  = '0;
        clear_tracker();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sync_search();
        test_checksum_error();
        test_random_frames();
        test_outside_range();
        test_output_backpressure();

        wait_drained();
        if (due_words.size() != 0)
            report_mismatch("words never delivered", 64'(due_words.size()), '0);
        $display("sent %0d bytes; %0d publish runs, %0d checksum errors, %0d quiet frames",
                 bytes_sent, n_publish, n_csum_err, n_quiet);
        $display("%0d frames with out-of-range type, %0d result words compared",
                 n_outside, words_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/ifp_pkg.sv
rtl/ifp_stream_if.sv
rtl/ifp_ram.sv
rtl/ifp_parser.sv
rtl/imu_serial_frame_parser_top.sv
tb/sv/imu_serial_frame_parser_top_test.sv
